// ===== rtl/sard_pkg.sv =====
package sard_pkg;

  localparam int unsigned SLOTS      = 1024;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned CFG_SLOT_W = 11;
  localparam int unsigned CNT_W      = (SLOT_W + 1 > CFG_SLOT_W) ? SLOT_W + 1 : CFG_SLOT_W;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESERVED_SLOTS = 3'd0,
    CFG_SLOTS_IN_USE   = 3'd1,
    CFG_START_GRACE    = 3'd2,
    CFG_REUSE_DELAY    = 3'd3,
    CFG_ID_RES_LOW     = 3'd4,
    CFG_ID_RES_HIGH    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic issue;
    logic restart;
  } id_ctrl_t;

  typedef struct packed {
    logic              free;
    logic [TIME_W-1:0] freed_at;
  } slot_entry_t;

endpackage

// ===== rtl/sard_id_gen.sv =====
module sard_id_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sard_pkg::id_ctrl_t         ctrl_i,
  input  logic [sard_pkg::ID_W-1:0]  res_low_i,
  input  logic [sard_pkg::ID_W-1:0]  res_high_i,
  output logic [sard_pkg::ID_W-1:0]  id_o
);

  logic [sard_pkg::ID_W-1:0] next_q;
  logic [sard_pkg::ID_W-1:0] next_d;
  logic [sard_pkg::ID_W-1:0] base;

  // jump over the reserved range before issuing
  always_comb begin
    base = (next_q == res_low_i - sard_pkg::ID_W'(1)) ? res_high_i + sard_pkg::ID_W'(1)
                                                     : next_q;
    id_o   = base;
    next_d = next_q;
    if (ctrl_i.restart) begin
      next_d = sard_pkg::ID_W'(1);
    end else if (ctrl_i.issue) begin
      next_d = base + sard_pkg::ID_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= sard_pkg::ID_W'(1);
    end else begin
      next_q <= next_d;
    end
  end

endmodule

// ===== rtl/slot_allocator_reuse_delay_unit.sv =====
// free and out-of-range free, and unused func codes: result in the cycle after the item is taken
// allocate: result registered after the scan, which reads at most 1024 slots,
//   one slot entry read per cycle from the slot memory
// clear: result registered after the pass, one read-modify-write of every slot per cycle
// the receiver cannot stall; the next item is taken at the earliest with the result
// after reset a clearing pass over all 1024 slots holds busy high; config writes are always taken
module slot_allocator_reuse_delay_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sard_pkg::FUNC_W-1:0]       func_i,
  input  logic [sard_pkg::SLOT_W-1:0]       slot_index_i,
  input  logic [sard_pkg::TIME_W-1:0]       now_i,
  output logic                              done_o,
  output logic [sard_pkg::STAT_W-1:0]       status_o,
  output logic [sard_pkg::SLOT_W-1:0]       granted_slot_o,
  output logic [sard_pkg::ID_W-1:0]         identifier_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sard_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sard_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SLOT_W = sard_pkg::SLOT_W;
  localparam int unsigned CNT_W  = sard_pkg::CNT_W;
  localparam int unsigned TIME_W = sard_pkg::TIME_W;
  localparam int unsigned ID_W   = sard_pkg::ID_W;
  localparam int unsigned CSW    = sard_pkg::CFG_SLOT_W;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  // configuration
  logic [CSW-1:0]    reserved_q;
  logic [CSW-1:0]    in_use_q;
  logic [TIME_W-1:0] grace_q;
  logic [TIME_W-1:0] delay_q;
  logic [ID_W-1:0]   id_low_q;
  logic [ID_W-1:0]   id_high_q;

  // control
  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  hw_q, hw_d;
  logic [CNT_W-1:0]  high_water_q, high_water_d;
  logic [SLOT_W-1:0] chk_q, chk_d;
  logic              rd_vld_q, rd_vld_d;
  logic [TIME_W-1:0] now_q, now_d;

  // result
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ID_W-1:0]   id_q, id_d;

  // slot memory
  sard_pkg::slot_entry_t mem_q [sard_pkg::SLOTS];
  sard_pkg::slot_entry_t rdata_q;
  sard_pkg::slot_entry_t mem_wdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [SLOT_W-1:0]     mem_raddr;

  sard_pkg::id_ctrl_t id_ctrl;
  logic [ID_W-1:0]    id_value;

  logic [CNT_W-1:0]  in_use_ext;
  logic [CNT_W-1:0]  reserved_ext;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  ext_slot;
  logic [TIME_W-1:0] rest;
  logic              reusable;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= CSW'(1);
      in_use_q   <= CSW'(1024);
      grace_q    <= TIME_W'(2000);
      delay_q    <= TIME_W'(500);
      id_low_q   <= ID_W'(1);
      id_high_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sard_pkg::CFG_RESERVED_SLOTS: reserved_q <= cfg_data_i[CSW-1:0];
        sard_pkg::CFG_SLOTS_IN_USE:   in_use_q   <= cfg_data_i[CSW-1:0];
        sard_pkg::CFG_START_GRACE:    grace_q    <= cfg_data_i[TIME_W-1:0];
        sard_pkg::CFG_REUSE_DELAY:    delay_q    <= cfg_data_i[TIME_W-1:0];
        sard_pkg::CFG_ID_RES_LOW:     id_low_q   <= cfg_data_i[ID_W-1:0];
        sard_pkg::CFG_ID_RES_HIGH:    id_high_q  <= cfg_data_i[ID_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_use_ext   = CNT_W'(in_use_q);
  assign reserved_ext = CNT_W'(reserved_q);
  assign cap          = (in_use_ext > CNT_W'(sard_pkg::SLOTS)) ? CNT_W'(sard_pkg::SLOTS)
                                                                : in_use_ext;
  assign ext_slot     = (reserved_ext > hw_q) ? reserved_ext : hw_q;

  // slot read last cycle: free, and either within the start grace or rested long enough
  assign rest     = now_q - rdata_q.freed_at;
  assign reusable = rdata_q.free &&
                    ((rdata_q.freed_at <= grace_q) ||
                     ((now_q >= rdata_q.freed_at) && (rest >= delay_q)));

  sard_id_gen u_id_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (id_ctrl),
    .res_low_i  (id_low_q),
    .res_high_i (id_high_q),
    .id_o       (id_value)
  );

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    hw_d         = hw_q;
    high_water_d = high_water_q;
    chk_d        = chk_q;
    rd_vld_d     = 1'b0;
    now_d        = now_q;
    done_d       = 1'b0;
    status_d     = sard_pkg::STAT_OK;
    slot_d       = '0;
    id_d         = '0;
    id_ctrl      = '0;
    mem_we       = 1'b0;
    mem_waddr    = chk_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[SLOT_W-1:0];

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[SLOT_W-1:0];
        ptr_d     = ptr_q + CNT_W'(1);
        if (ptr_q == CNT_W'(sard_pkg::SLOTS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          now_d = now_i;
          unique case (func_i)
            sard_pkg::FUNC_ALLOC: begin
              ptr_d   = reserved_ext;
              hw_d    = (high_water_q < cap) ? high_water_q : cap;
              state_d = ST_SCAN;
            end
            sard_pkg::FUNC_FREE: begin
              done_d = 1'b1;
              if (CNT_W'(slot_index_i) >= cap) begin
                status_d = sard_pkg::STAT_BAD_INDEX;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = slot_index_i;
                mem_wdata.free     = 1'b1;
                mem_wdata.freed_at = now_i;
              end
            end
            sard_pkg::FUNC_CLEAR: begin
              ptr_d   = '0;
              state_d = ST_CLR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && reusable) begin
          mem_we             = 1'b1;
          mem_waddr          = chk_q;
          mem_wdata.freed_at = rdata_q.freed_at;
          id_ctrl.issue      = 1'b1;
          done_d             = 1'b1;
          slot_d             = chk_q;
          id_d               = id_value;
          state_d            = ST_IDLE;
        end else if (ptr_q < hw_q) begin
          mem_re   = 1'b1;
          chk_d    = ptr_q[SLOT_W-1:0];
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CNT_W'(1);
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (ext_slot >= cap) begin
            status_d = sard_pkg::STAT_FULL;
          end else begin
            high_water_d  = ext_slot + CNT_W'(1);
            mem_we        = 1'b1;
            mem_waddr     = ext_slot[SLOT_W-1:0];
            id_ctrl.issue = 1'b1;
            slot_d        = ext_slot[SLOT_W-1:0];
            id_d          = id_value;
          end
        end
      end
      ST_CLR: begin
        // write back the slot read last cycle while reading the next one
        if (rd_vld_q && !rdata_q.free) begin
          mem_we             = 1'b1;
          mem_waddr          = chk_q;
          mem_wdata.free     = 1'b1;
          mem_wdata.freed_at = now_q;
        end
        if (ptr_q == CNT_W'(sard_pkg::SLOTS)) begin
          done_d          = 1'b1;
          high_water_d    = reserved_ext;
          id_ctrl.restart = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          mem_re   = 1'b1;
          chk_d    = ptr_q[SLOT_W-1:0];
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_INIT;
        ptr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      ptr_q        <= '0;
      hw_q         <= '0;
      high_water_q <= CNT_W'(1);
      chk_q        <= '0;
      rd_vld_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      hw_q         <= hw_d;
      high_water_q <= high_water_d;
      chk_q        <= chk_d;
      rd_vld_q     <= rd_vld_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    id_q     <= id_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = slot_q;
  assign identifier_o   = id_q;

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("slot memory read and written at one entry");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ptr_q > reserved_ext) |-> (ptr_q <= hw_q))
    else $error("scan pointer beyond high-water mark");

  a_full_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == sard_pkg::STAT_FULL) |-> (granted_slot_o == '0 && identifier_o == '0))
    else $error("full result carries a slot or identifier");

  a_busy_no_done_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !done_o)
    else $error("result during clearing pass");

endmodule

// ===== tb/slot_reply_checker.sv =====
`timescale 1ns / 100ps

module slot_reply_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [sard_pkg::FUNC_W-1:0]     func_i,
  input  logic [sard_pkg::SLOT_W-1:0]     slot_index_i,
  input  logic [sard_pkg::TIME_W-1:0]     now_i,
  input  logic                            done_i,
  input  logic [sard_pkg::STAT_W-1:0]     status_i,
  input  logic [sard_pkg::SLOT_W-1:0]     granted_slot_i,
  input  logic [sard_pkg::ID_W-1:0]       identifier_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [sard_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sard_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatches_o,
  output int                              awaiting_o
);

  localparam int unsigned SLOTS      = sard_pkg::SLOTS;
  localparam int unsigned SLOT_W     = sard_pkg::SLOT_W;
  localparam int unsigned TIME_W     = sard_pkg::TIME_W;
  localparam int unsigned ID_W       = sard_pkg::ID_W;
  localparam int unsigned CFG_SLOT_W = sard_pkg::CFG_SLOT_W;
  localparam int unsigned CFG_DATA_W = sard_pkg::CFG_DATA_W;

  typedef struct packed {
    sard_pkg::status_e status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } slot_reply_t;

  logic [CFG_SLOT_W-1:0] reserved_q;
  logic [CFG_SLOT_W-1:0] in_use_q;
  logic [TIME_W-1:0]     grace_q;
  logic [TIME_W-1:0]     delay_q;
  logic [ID_W-1:0]       id_low_q;
  logic [ID_W-1:0]       id_high_q;

  bit                    slot_free_q [SLOTS];
  logic [TIME_W-1:0]     freed_at_q  [SLOTS];
  int unsigned           high_water_q;
  logic [ID_W-1:0]       next_id_q;

  slot_reply_t           awaited_replies [$];
  slot_reply_t           predicted;
  slot_reply_t           oldest;

  initial begin
    mismatches_o = 0;
    awaiting_o   = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, seen, wanted);
    mismatches_o++;
  endtask

  task automatic reset_allocator();
    int unsigned i;
    reserved_q = 11'd1;
    in_use_q   = 11'd1024;
    grace_q    = 32'd2000;
    delay_q    = 32'd500;
    id_low_q   = 32'd1;
    id_high_q  = 32'd0;
    for (i = 0; i < SLOTS; i++) begin
      slot_free_q[i] = 1'b0;
      freed_at_q[i]  = '0;
    end
    high_water_q = reserved_q;
    next_id_q    = 32'd1;
  endtask

  task automatic apply_setting(input sard_pkg::cfg_idx_e idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      sard_pkg::CFG_RESERVED_SLOTS: reserved_q = data[CFG_SLOT_W-1:0];
      sard_pkg::CFG_SLOTS_IN_USE:   in_use_q   = data[CFG_SLOT_W-1:0];
      sard_pkg::CFG_START_GRACE:    grace_q    = data;
      sard_pkg::CFG_REUSE_DELAY:    delay_q    = data;
      sard_pkg::CFG_ID_RES_LOW:     id_low_q   = data;
      sard_pkg::CFG_ID_RES_HIGH:    id_high_q  = data;
      default: ;
    endcase
  endtask

  function automatic bit slot_reusable(input int unsigned s, input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] stamp;
    stamp = freed_at_q[s];
    if (!slot_free_q[s]) return 1'b0;
    if (stamp <= grace_q) return 1'b1;
    return (t >= stamp) && ((t - stamp) >= delay_q);
  endfunction

  // skips the reserved range, wraps modulo 2^32
  function automatic logic [ID_W-1:0] next_identifier();
    logic [ID_W-1:0] id;
    if (next_id_q == id_low_q - 32'd1) next_id_q = id_high_q + 32'd1;
    id        = next_id_q;
    next_id_q = next_id_q + 32'd1;
    return id;
  endfunction

  task automatic compute_reply(input sard_pkg::func_e op, input logic [SLOT_W-1:0] idx,
                               input logic [TIME_W-1:0] t, output slot_reply_t r);
    int unsigned cap;
    int unsigned first;
    int unsigned hw;
    int unsigned i;
    int unsigned pick;
    bit          found;
    r.status = sard_pkg::STAT_OK;
    r.slot   = '0;
    r.id     = '0;
    cap = (in_use_q < SLOTS) ? in_use_q : SLOTS;
    case (op)
      sard_pkg::FUNC_ALLOC: begin
        first = reserved_q;
        hw    = (high_water_q < cap) ? high_water_q : cap;
        found = 1'b0;
        pick  = 0;
        for (i = first; i < hw; i++) begin
          if (!found && slot_reusable(i, t)) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (!found) begin
          pick = (first > hw) ? first : hw;
          if (pick >= cap) begin
            r.status = sard_pkg::STAT_FULL;
          end else begin
            high_water_q = pick + 1;
            found        = 1'b1;
          end
        end
        if (found) begin
          slot_free_q[pick] = 1'b0;
          r.slot = SLOT_W'(pick);
          r.id   = next_identifier();
        end
      end
      sard_pkg::FUNC_FREE: begin
        if (idx >= cap) begin
          r.status = sard_pkg::STAT_BAD_INDEX;
        end else begin
          slot_free_q[idx] = 1'b1;
          freed_at_q[idx]  = t;
        end
      end
      sard_pkg::FUNC_CLEAR: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_free_q[i]) begin
            slot_free_q[i] = 1'b1;
            freed_at_q[i]  = t;
          end
        end
        high_water_q = reserved_q;
        next_id_q    = 32'd1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_allocator();
      awaited_replies.delete();
    end else begin
      if (done_i) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply with no item awaiting it, status", status_i, '0);
        end else begin
          oldest = awaited_replies.pop_front();
          if (status_i !== oldest.status)
            report_mismatch("status", status_i, oldest.status);
          if (granted_slot_i !== oldest.slot)
            report_mismatch("granted_slot", granted_slot_i, oldest.slot);
          if (identifier_i !== oldest.id)
            report_mismatch("identifier", identifier_i, oldest.id);
        end
      end
      if (cfg_valid_i && cfg_ready_i)
        apply_setting(sard_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (start_i && !busy_i) begin
        compute_reply(sard_pkg::func_e'(func_i), slot_index_i, now_i, predicted);
        awaited_replies = {awaited_replies, predicted};
      end
    end
    awaiting_o = awaited_replies.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FUNC_W     = sard_pkg::FUNC_W;
  localparam int unsigned SLOT_W     = sard_pkg::SLOT_W;
  localparam int unsigned TIME_W     = sard_pkg::TIME_W;
  localparam int unsigned STAT_W     = sard_pkg::STAT_W;
  localparam int unsigned ID_W       = sard_pkg::ID_W;
  localparam int unsigned CFG_IDX_W  = sard_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = sard_pkg::CFG_DATA_W;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     func;
  logic [SLOT_W-1:0]     slot_index;
  logic [TIME_W-1:0]     now;
  logic                  done;
  logic [STAT_W-1:0]     status;
  logic [SLOT_W-1:0]     granted_slot;
  logic [ID_W-1:0]       identifier;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    mismatches;
  int                    awaiting;
  int unsigned           cycle_count = 0;
  int unsigned           idle_pct;
  logic [TIME_W-1:0]     tick;

  slot_allocator_reuse_delay_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func),
    .slot_index_i   (slot_index),
    .now_i          (now),
    .done_o         (done),
    .status_o       (status),
    .granted_slot_o (granted_slot),
    .identifier_o   (identifier),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  slot_reply_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func),
    .slot_index_i   (slot_index),
    .now_i          (now),
    .done_i         (done),
    .status_i       (status),
    .granted_slot_i (granted_slot),
    .identifier_i   (identifier),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .awaiting_o     (awaiting)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // entered at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input sard_pkg::func_e op, input logic [SLOT_W-1:0] idx,
                           input logic [TIME_W-1:0] t);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start      <= 1'b1;
    func       <= op;
    slot_index <= idx;
    now        <= t;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (awaiting != 0 || busy);
  endtask

  task automatic write_reg(input sard_pkg::cfg_idx_e idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [31:0] rsv, input logic [31:0] in_use,
                                input logic [31:0] grace, input logic [31:0] delay,
                                input logic [31:0] id_lo, input logic [31:0] id_hi);
    write_reg(sard_pkg::CFG_RESERVED_SLOTS, rsv);
    write_reg(sard_pkg::CFG_SLOTS_IN_USE, in_use);
    write_reg(sard_pkg::CFG_START_GRACE, grace);
    write_reg(sard_pkg::CFG_REUSE_DELAY, delay);
    write_reg(sard_pkg::CFG_ID_RES_LOW, id_lo);
    write_reg(sard_pkg::CFG_ID_RES_HIGH, id_hi);
    cfg_valid <= 1'b0;
  endtask

  // mostly allocate and free with time moving forward, some clears and noise
  task automatic random_items(input int unsigned n, input int unsigned cap);
    int unsigned       k;
    int unsigned       r;
    sard_pkg::func_e   op;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] t;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) tick = $urandom;
      else tick = tick + $urandom_range(0, 30);
      t = ($urandom_range(0, 99) < 3) ? $urandom : tick;
      if ($urandom_range(0, 99) < 15) idx = SLOT_W'($urandom);
      else idx = SLOT_W'($urandom_range(0, (cap > 1023) ? 1023 : cap));
      if (r < 55) op = sard_pkg::FUNC_ALLOC;
      else if (r < 88) op = sard_pkg::FUNC_FREE;
      else if (r < 95) op = sard_pkg::FUNC_CLEAR;
      else op = sard_pkg::FUNC_NONE;
      send_item(op, idx, t);
    end
  endtask

  task automatic run_phase(input logic [31:0] rsv, input logic [31:0] in_use,
                           input logic [31:0] grace, input logic [31:0] delay,
                           input logic [31:0] id_lo, input logic [31:0] id_hi,
                           input int unsigned n, input logic [TIME_W-1:0] first_tick);
    wait_idle();
    write_settings(rsv, in_use, grace, delay, id_lo, id_hi);
    tick = first_tick;
    random_items(n, in_use);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    func       = sard_pkg::FUNC_ALLOC;
    slot_index = '0;
    now        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = sard_pkg::CFG_RESERVED_SLOTS;
    cfg_data   = '0;
    tick       = '0;
    idle_pct   = 13;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // four slots, no grace, short delay, reserved ids force a skip and a wrap
    wait_idle();
    write_settings(32'd1, 32'd4, 32'd0, 32'd10, 32'd3, 32'hFFFF_FFFE);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd100);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd100);
    send_item(sard_pkg::FUNC_ALLOC, 10'd1023, 32'd100);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd100);
    send_item(sard_pkg::FUNC_FREE, 10'd2, 32'd200);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd205);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd210);
    send_item(sard_pkg::FUNC_FREE, 10'd3, 32'hFFFF_FFFF);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd300);
    send_item(sard_pkg::FUNC_FREE, 10'd4, 32'd300);
    send_item(sard_pkg::FUNC_FREE, 10'd1023, 32'd0);
    send_item(sard_pkg::FUNC_FREE, 10'd0, 32'd300);
    send_item(sard_pkg::FUNC_NONE, 10'd1023, 32'hFFFF_FFFF);
    send_item(sard_pkg::FUNC_CLEAR, 10'd0, 32'd400);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd400);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd400);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd415);
    send_item(sard_pkg::FUNC_ALLOC, 10'd0, 32'd415);

    idle_pct = 13;
    run_phase(32'd1, 32'd16, 32'd0, 32'd40, 32'd5, 32'd20, 70, 32'd5000);
    run_phase(32'd3, 32'd1024, 32'd2000, 32'd0, 32'd1, 32'd0, 80, 32'd0);
    run_phase(32'd1023, 32'd1024, 32'd0, 32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 30,
              32'd9000);
    idle_pct = 73;
    run_phase(32'd2, 32'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFE, 80,
              32'd7000);
    run_phase(32'd1, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 25, 32'd3000);
    run_phase(32'd4, 32'd40, 32'd100, 32'd25, 32'd10, 32'd15, 90, 32'd50);
    idle_pct = 0;
    run_phase(32'd1, 32'd1023, 32'd0, 32'd5, 32'd1000, 32'd2000, 90, 32'hFFFF_FF00);
    run_phase(32'd1, 32'd20, 32'd2000, 32'd500, 32'd1, 32'd0, 90, 32'd1500);

    wait_idle();
    repeat (1100) @(negedge clk_i);
    if (mismatches == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
